[rtl/kehs_pkg.sv]
// Package for the key exchange handshake engine: phase codes, register
// indexes, link characters and the structs passed between the engine parts.
// No dependencies.
`default_nettype none

package kehs_pkg;

   localparam logic [7:0]  CH_C          = 8'h43;
   localparam logic [7:0]  CH_A          = 8'h41;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   // beats of a key group: lead byte, four key bytes, four modulus bytes
   localparam int unsigned GROUP_BEATS = 9;
   localparam int unsigned BEAT_W      = $clog2(GROUP_BEATS);
   localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(GROUP_BEATS - 1);

   // peer key arrives as eight bytes; seven are held before the last one
   localparam int unsigned KEY_BYTES = 8;
   localparam int unsigned KCNT_W    = $clog2(KEY_BYTES);
   localparam logic [KCNT_W-1:0] KCNT_LAST = KCNT_W'(KEY_BYTES - 1);

   typedef enum logic [1:0] {
      CSR_IS_SERVER = 2'd0,
      CSR_OWN_KEY   = 2'd1,
      CSR_OWN_MOD   = 2'd2,
      CSR_TIMEOUT   = 2'd3
   } csr_index_type;

   typedef enum logic [7:0] {
      PH_CL_START  = 8'b0000_0001,
      PH_CL_ACK    = 8'b0000_0010,
      PH_CL_KEY    = 8'b0000_0100,
      PH_SV_LISTEN = 8'b0000_1000,
      PH_SV_KEY1   = 8'b0001_0000,
      PH_SV_ACK    = 8'b0010_0000,
      PH_SV_KEY2   = 8'b0100_0000,
      PH_DONE      = 8'b1000_0000
   } phase_type;

   // what one input asks the emitter to send
   typedef struct packed {
      logic       valid;
      logic [7:0] lead;
      logic       group;
      logic       has_byte;
      logic       connected;
   } plan_type;

   typedef struct packed {
      logic [31:0] own_key;
      logic [31:0] own_mod;
      logic [31:0] peer_key;
      logic [31:0] peer_mod;
   } keys_type;

endpackage

`default_nettype wire

[rtl/kehs_fsm.sv]
// Handshake state machine: configuration registers, phase, wait timer and
// peer key assembly. Produces at most one send plan per accepted item. Uses kehs_pkg.
`default_nettype none

module kehs_fsm import kehs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic        req_type,
   input  wire logic [7:0]  rx_byte,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output plan_type         plan,
   output keys_type         keys
);

   logic                is_server_ff;
   logic [31:0]         own_key_ff;
   logic [31:0]         own_mod_ff;
   logic [15:0]         timeout_ff;
   phase_type           phase_ff, phase_in;
   logic [KCNT_W-1:0]   bytes_ff, bytes_in;
   logic [15:0]         wait_ff, wait_in;
   logic [55:0]         shift_ff, shift_in;
   logic [31:0]         peer_key_ff, peer_key_in;
   logic [31:0]         peer_mod_ff, peer_mod_in;
   plan_type            plan_in;

   logic [15:0]         wait_inc;
   logic                expired;
   logic                key_done;
   csr_index_type       csr_sel;

   assign csr_sel  = csr_index_type'(csr_index);
   assign wait_inc = (wait_ff == 16'hFFFF) ? wait_ff : wait_ff + 16'd1;
   assign expired  = (wait_inc >= timeout_ff);
   assign key_done = (bytes_ff == KCNT_LAST);

   always_comb begin
      phase_in    = phase_ff;
      bytes_in    = bytes_ff;
      wait_in     = wait_ff;
      shift_in    = shift_ff;
      peer_key_in = peer_key_ff;
      peer_mod_in = peer_mod_ff;
      plan_in     = '0;

      unique case (phase_ff)
         PH_CL_START: begin
            plan_in  = '{valid: 1'b1, lead: CH_C, group: 1'b1, has_byte: 1'b1,
                         connected: 1'b0};
            phase_in = PH_CL_ACK;
            wait_in  = '0;
            bytes_in = '0;
         end
         PH_CL_ACK, PH_CL_KEY, PH_SV_LISTEN, PH_SV_KEY1, PH_SV_KEY2, PH_SV_ACK: begin
            if (req_type) begin
               wait_in = wait_inc;
               if (expired) begin
                  wait_in  = '0;
                  bytes_in = '0;
                  if (phase_ff == PH_CL_ACK || phase_ff == PH_CL_KEY) begin
                     // resend the key group and wait for 'A' again
                     plan_in  = '{valid: 1'b1, lead: CH_C, group: 1'b1,
                                  has_byte: 1'b1, connected: 1'b0};
                     phase_in = PH_CL_ACK;
                  end else begin
                     phase_in = PH_SV_LISTEN;
                  end
               end
            end else if (phase_ff == PH_CL_KEY || phase_ff == PH_SV_KEY1 ||
                         phase_ff == PH_SV_KEY2) begin
               if (key_done) begin
                  peer_key_in = shift_ff[31:0];
                  peer_mod_in = {rx_byte, shift_ff[55:32]};
                  wait_in     = '0;
                  bytes_in    = '0;
                  if (phase_ff == PH_CL_KEY) begin
                     plan_in  = '{valid: 1'b1, lead: CH_A, group: 1'b0,
                                  has_byte: 1'b1, connected: 1'b1};
                     phase_in = PH_DONE;
                  end else begin
                     if (phase_ff == PH_SV_KEY1) begin
                        plan_in = '{valid: 1'b1, lead: CH_A, group: 1'b1,
                                    has_byte: 1'b1, connected: 1'b0};
                     end
                     phase_in = PH_SV_ACK;
                  end
               end else begin
                  shift_in = {rx_byte, shift_ff[55:8]};
                  bytes_in = bytes_ff + KCNT_W'(1);
               end
            end else begin
               // single-byte waits: any byte restarts the wait
               wait_in  = '0;
               bytes_in = '0;
               if (phase_ff == PH_CL_ACK && rx_byte == CH_A) begin
                  phase_in = PH_CL_KEY;
               end else if (phase_ff == PH_SV_LISTEN && rx_byte == CH_C) begin
                  phase_in = PH_SV_KEY1;
               end else if (phase_ff == PH_SV_ACK && rx_byte == CH_A) begin
                  plan_in  = '{valid: 1'b1, lead: 8'h00, group: 1'b0,
                               has_byte: 1'b0, connected: 1'b1};
                  phase_in = PH_DONE;
               end else if (phase_ff == PH_SV_ACK && rx_byte == CH_C) begin
                  phase_in = PH_SV_KEY2;
               end
            end
         end
         PH_DONE: begin
         end
         default: begin
            phase_in = is_server_ff ? PH_SV_LISTEN : PH_CL_START;
            wait_in  = '0;
            bytes_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_server_ff <= 1'b0;
         own_key_ff   <= '0;
         own_mod_ff   <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         phase_ff     <= PH_CL_START;
         bytes_ff     <= '0;
         wait_ff      <= '0;
         peer_key_ff  <= '0;
         peer_mod_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_sel)
            CSR_IS_SERVER: begin
               is_server_ff <= csr_wdata[0];
               phase_ff     <= csr_wdata[0] ? PH_SV_LISTEN : PH_CL_START;
               bytes_ff     <= '0;
               wait_ff      <= '0;
            end
            CSR_OWN_KEY: own_key_ff <= csr_wdata;
            CSR_OWN_MOD: own_mod_ff <= csr_wdata;
            CSR_TIMEOUT: timeout_ff <= csr_wdata[15:0];
         endcase
      end else if (accept) begin
         phase_ff    <= phase_in;
         bytes_ff    <= bytes_in;
         wait_ff     <= wait_in;
         peer_key_ff <= peer_key_in;
         peer_mod_ff <= peer_mod_in;
      end
   end

   // partial key bytes carry no reset; the byte count decides what is used
   always_ff @(posedge clock) begin
      if (accept) begin
         shift_ff <= shift_in;
      end
   end

   assign plan = accept ? plan_in : '0;
   assign keys = '{own_key: own_key_ff, own_mod: own_mod_ff,
                   peer_key: peer_key_ff, peer_mod: peer_mod_ff};

`ifndef SYNTH
   a_conn_done: assert property (@(posedge clock) disable iff (reset)
      accept && plan_in.connected && !csr_we |=> phase_ff == PH_DONE)
      else $error("connected plan did not reach done phase");
   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |-> !plan_in.valid)
      else $error("done phase produced a plan");
   a_key_count: assert property (@(posedge clock) disable iff (reset)
      accept && !csr_we && bytes_ff != '0 && phase_in != PH_DONE &&
      phase_in != PH_SV_ACK && !req_type
      |=> bytes_ff == $past(bytes_ff) + KCNT_W'(1) || bytes_ff == '0)
      else $error("key byte count skipped");
`endif

endmodule

`default_nettype wire

[rtl/kehs_emit.sv]
// Result serializer: holds one send plan and issues its beats, a full key
// group or a single beat, one per cycle while rsp_tready is high. Uses kehs_pkg.
`default_nettype none

module kehs_emit import kehs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  plan_type         plan,
   input  keys_type         keys,
   output logic             plan_ready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);

   logic              valid_ff, valid_in;
   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic [7:0]        lead_ff;
   logic              group_ff;
   logic              has_byte_ff;
   logic              connected_ff;
   logic              last;
   logic [7:0]        tx_byte;

   assign last       = !group_ff || (beat_ff == LAST_BEAT);
   assign plan_ready = !valid_ff || (rsp_tready && last);

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (plan.valid) begin
         valid_in = 1'b1;
         beat_in  = '0;
      end else if (valid_ff && rsp_tready) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            beat_in = beat_ff + BEAT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         beat_ff  <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (plan.valid) begin
         lead_ff      <= plan.lead;
         group_ff     <= plan.group;
         has_byte_ff  <= plan.has_byte;
         connected_ff <= plan.connected;
      end
   end

   always_comb begin
      unique case (beat_ff)
         BEAT_W'(1): tx_byte = keys.own_key[7:0];
         BEAT_W'(2): tx_byte = keys.own_key[15:8];
         BEAT_W'(3): tx_byte = keys.own_key[23:16];
         BEAT_W'(4): tx_byte = keys.own_key[31:24];
         BEAT_W'(5): tx_byte = keys.own_mod[7:0];
         BEAT_W'(6): tx_byte = keys.own_mod[15:8];
         BEAT_W'(7): tx_byte = keys.own_mod[23:16];
         BEAT_W'(8): tx_byte = keys.own_mod[31:24];
         default:    tx_byte = lead_ff;
      endcase
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {keys.peer_mod, keys.peer_key, tx_byte};
   assign rsp_tuser  = {connected_ff, has_byte_ff};
   assign rsp_tlast  = last;

`ifndef SYNTH
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      plan.valid |-> !valid_ff || (rsp_tready && last))
      else $error("plan loaded over a pending beat");
   a_beat_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> beat_ff <= LAST_BEAT)
      else $error("beat counter out of range");
   a_group_cont: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_tready && !last |=> valid_ff && beat_ff == $past(beat_ff) + BEAT_W'(1))
      else $error("key group broken off");
   a_nobyte_conn: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !has_byte_ff |-> connected_ff && last && tx_byte == 8'h00)
      else $error("empty beat that is not the connect beat");
`endif

endmodule

`default_nettype wire

[rtl/key_exchange_handshake_fsm_core.sv]
// The first result beat of an item is presented in the cycle after the item is accepted.
// Result beats go out one per cycle while rsp_tready is high; an item causing N beats (up to 9,
// set by the key group serializer) holds the input until its last beat is taken.
// Reset (synchronous, active high): client role, start phase, timeout 1000 ticks,
// keys cleared, no beat pending.
`default_nettype none

module key_exchange_handshake_fsm_core import kehs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic        req_tuser,   // [0] req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [7:0] tx_byte, [39:8] peer_public_key,
                                         // [71:40] peer_modulus
   output logic [1:0]       rsp_tuser,   // [0] has_byte, [1] connected
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   plan_type plan;
   keys_type keys;
   logic     plan_ready;
   logic     accept;

   // hold off input beats during reset and register writes
   assign req_tready = plan_ready && !reset && !csr_we;
   assign accept     = req_tvalid && req_tready;

   kehs_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_type  (req_tuser),
      .rx_byte   (req_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .plan      (plan),
      .keys      (keys)
   );

   kehs_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .plan       (plan),
      .keys       (keys),
      .plan_ready (plan_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

[dv/kehs_check_pkg.sv]
// Scoreboard for the key exchange handshake engine: input and beat types and a class that
// predicts the transmitted beats of every accepted input and checks them in order.
// Depends on kehs_pkg for phase codes, register indexes and link characters.
package kehs_check_pkg;

   import kehs_pkg::*;

   typedef enum logic {
      REQ_BYTE = 1'b0,
      REQ_TICK = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic        has_byte;
      logic [7:0]  tx_byte;
      logic        last;
      logic        connected;
      logic [31:0] peer_public_key;
      logic [31:0] peer_modulus;
   } link_beat_type;

   class handshake_scoreboard;
      logic          is_server;
      logic [31:0]   own_key;
      logic [31:0]   own_mod;
      logic [15:0]   timeout_ticks;
      phase_type     phase;
      logic [3:0]    bytes_seen;
      logic [15:0]   wait_timer;
      logic [63:0]   key_shift;
      logic [31:0]   peer_key;
      logic [31:0]   peer_mod;
      link_beat_type beats_due[$];
      link_beat_type reply[$];
      int            mismatches;

      function new();
         is_server     = 1'b0;
         own_key       = '0;
         own_mod       = '0;
         timeout_ticks = TIMEOUT_RESET;
         peer_key      = '0;
         peer_mod      = '0;
         mismatches    = 0;
         restart_role();
      endfunction

      function void clear_wait();
         wait_timer = '0;
         bytes_seen = '0;
         key_shift  = '0;
      endfunction

      function void restart_role();
         phase = is_server ? PH_SV_LISTEN : PH_CL_START;
         clear_wait();
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_IS_SERVER: begin
               is_server = value[0];
               restart_role();
            end
            CSR_OWN_KEY: own_key = value;
            CSR_OWN_MOD: own_mod = value;
            CSR_TIMEOUT: timeout_ticks = value[15:0];
            default: ;
         endcase
      endfunction

      function void add_beat(logic has_byte, logic [7:0] tx_byte, logic connected);
         link_beat_type b;
         b                 = '0;
         b.has_byte        = has_byte;
         b.tx_byte         = tx_byte;
         b.connected       = connected;
         reply.push_back(b);
      endfunction

      function void send_group(logic [7:0] lead);
         add_beat(1'b1, lead, 1'b0);
         for (int i = 0; i < 4; i++) add_beat(1'b1, own_key[8*i +: 8], 1'b0);
         for (int i = 0; i < 4; i++) add_beat(1'b1, own_mod[8*i +: 8], 1'b0);
      endfunction

      // shift one key byte in from the top; latch key and modulus on the eighth
      function bit take_key_byte(logic [7:0] rx);
         key_shift  = {rx, key_shift[63:8]};
         bytes_seen = bytes_seen + 4'd1;
         if (bytes_seen >= 4'd8) begin
            peer_key = key_shift[31:0];
            peer_mod = key_shift[63:32];
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function bit tick_expired();
         if (wait_timer != 16'hFFFF) wait_timer = wait_timer + 16'd1;
         return wait_timer >= timeout_ticks;
      endfunction

      function void note_rx_item(req_kind_type kind, logic [7:0] rx);
         link_beat_type b;
         bit            is_tick;
         is_tick = (kind == REQ_TICK);
         reply.delete();
         case (phase)
            PH_CL_START: begin
               send_group(CH_C);
               phase = PH_CL_ACK;
               clear_wait();
            end
            PH_CL_ACK, PH_CL_KEY: begin
               if (is_tick) begin
                  if (tick_expired()) begin
                     send_group(CH_C);
                     phase = PH_CL_ACK;
                     clear_wait();
                  end
               end else if (phase == PH_CL_ACK) begin
                  if (rx == CH_A) phase = PH_CL_KEY;
                  clear_wait();
               end else if (take_key_byte(rx)) begin
                  add_beat(1'b1, CH_A, 1'b1);
                  phase = PH_DONE;
                  clear_wait();
               end
            end
            PH_SV_LISTEN: begin
               if (is_tick) begin
                  if (tick_expired()) clear_wait();
               end else begin
                  if (rx == CH_C) phase = PH_SV_KEY1;
                  clear_wait();
               end
            end
            PH_SV_KEY1, PH_SV_KEY2: begin
               if (is_tick) begin
                  if (tick_expired()) begin
                     phase = PH_SV_LISTEN;
                     clear_wait();
                  end
               end else if (take_key_byte(rx)) begin
                  // only the first key collection is answered
                  if (phase == PH_SV_KEY1) send_group(CH_A);
                  phase = PH_SV_ACK;
                  clear_wait();
               end
            end
            PH_SV_ACK: begin
               if (is_tick) begin
                  if (tick_expired()) begin
                     phase = PH_SV_LISTEN;
                     clear_wait();
                  end
               end else if (rx == CH_A) begin
                  add_beat(1'b0, 8'h00, 1'b1);
                  phase = PH_DONE;
                  clear_wait();
               end else begin
                  if (rx == CH_C) phase = PH_SV_KEY2;
                  clear_wait();
               end
            end
            PH_DONE: ;
            default: restart_role();
         endcase
         foreach (reply[i]) begin
            b                 = reply[i];
            b.peer_public_key = peer_key;
            b.peer_modulus    = peer_mod;
            b.last            = (i == reply.size() - 1);
            beats_due.push_back(b);
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_link_beat(link_beat_type got);
         link_beat_type want;
         if (beats_due.size() == 0) begin
            $error("link beat with nothing pending: tx_byte %0h", got.tx_byte);
            mismatches++;
            return;
         end
         want = beats_due.pop_front();
         compare_field("has_byte", 32'(want.has_byte), 32'(got.has_byte));
         compare_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
         compare_field("last", 32'(want.last), 32'(got.last));
         compare_field("connected", 32'(want.connected), 32'(got.connected));
         compare_field("peer_public_key", want.peer_public_key, got.peer_public_key);
         compare_field("peer_modulus", want.peer_modulus, got.peer_modulus);
      endfunction
   endclass

endpackage

[dv/testbench.sv]
// Top of the handshake engine bench: clock, reset, stream drivers, register writes and a
// cycle watchdog around key_exchange_handshake_fsm_core.
// Depends on kehs_pkg and kehs_check_pkg.
module testbench;

   import kehs_pkg::*;
   import kehs_check_pkg::*;

   localparam int TARGET_ITEMS   = 400;
   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 4;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 1000;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata  = 8'h00;   // [7:0] rx_byte
   logic          req_tuser  = 1'b0;    // [0] req_type
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [71:0]   rsp_tdata;            // [7:0] tx_byte, [39:8] peer_public_key,
                                        // [71:40] peer_modulus
   logic [1:0]    rsp_tuser;            // [0] has_byte, [1] connected
   logic          rsp_tlast;
   logic          csr_we     = 1'b0;
   csr_index_type csr_index  = CSR_IS_SERVER;
   logic [31:0]   csr_wdata  = 32'h0;

   handshake_scoreboard sb;
   bit gaps_on   = 1'b1;
   bit hold_rsp  = 1'b0;
   int items_sent = 0;

   key_exchange_handshake_fsm_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic send_item(input req_kind_type kind, input logic [7:0] rx);
      int gap;
      gap = gaps_on ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_rx_item(kind, rx);
      items_sent++;
   endtask

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 3))
         0: return CH_C;
         1: return CH_A;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_noise();
      send_item($urandom_range(0, 1) ? REQ_TICK : REQ_BYTE, noise_byte());
   endtask

   task automatic send_key_bytes();
      repeat (8) begin
         if ($urandom_range(0, 9) == 0) send_item(REQ_TICK, 8'($urandom));
         send_item(REQ_BYTE, 8'($urandom));
      end
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // drop valid and wait until every pending beat is out and the engine is idle
   task automatic drain_link();
      req_tvalid <= 1'b0;
      while (sb.beats_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input csr_index_type idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   // mask bit i selects register i; the role goes last
   task automatic apply_settings(input logic [3:0] mask, input logic role,
                                 input logic [31:0] key, input logic [31:0] modulus,
                                 input logic [15:0] ticks);
      if (mask[CSR_OWN_KEY]) csr_put(CSR_OWN_KEY, key);
      if (mask[CSR_OWN_MOD]) csr_put(CSR_OWN_MOD, modulus);
      if (mask[CSR_TIMEOUT]) csr_put(CSR_TIMEOUT, {16'h0, ticks});
      if (mask[CSR_IS_SERVER]) csr_put(CSR_IS_SERVER, {31'h0, role});
      csr_we <= 1'b0;
   endtask

   initial begin
      int          session;
      logic        role;
      logic [15:0] ticks;
      logic [7:0]  key_bytes [8];
      key_bytes = '{8'hFF, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC};
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // client from reset: the opening byte is swallowed by the key group
      apply_settings(4'b0110, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 16'd0);
      send_item(REQ_BYTE, 8'hFF);
      send_item(REQ_BYTE, 8'h00);
      send_item(REQ_BYTE, CH_A);
      foreach (key_bytes[i]) send_item(REQ_BYTE, key_bytes[i]);
      send_item(REQ_TICK, 8'hFF);
      drain_link();

      // server with a zero timeout, which behaves as one tick
      apply_settings(4'b1111, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 16'd0);
      send_item(REQ_TICK, 8'h00);
      send_item(REQ_BYTE, CH_C);
      send_item(REQ_TICK, 8'h55);
      send_item(REQ_BYTE, CH_C);
      foreach (key_bytes[i]) send_item(REQ_BYTE, key_bytes[7 - i]);
      drain_link();

      session = 0;
      while (items_sent < TARGET_ITEMS) begin
         role    = 1'($urandom_range(0, 1));
         gaps_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 7))
            0: ticks = 16'd1;
            1: ticks = 16'd2;
            2: ticks = 16'($urandom_range(3, 8));
            3: ticks = 16'hFFFF;
            4: ticks = 16'($urandom_range(1, 65535));
            default: ticks = 16'($urandom_range(4, 20));
         endcase
         // one client run with the receiver held off so the engine backs up
         if (session == 1) begin
            role     = 1'b0;
            hold_rsp = 1'b1;
         end
         apply_settings({3'($urandom), 1'b1}, role, pick_word(), pick_word(), ticks);
         if (session != 1 && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(8, 20)) send_noise();
         end else if (role) begin
            repeat ($urandom_range(0, 1)) send_noise();
            send_item(REQ_BYTE, CH_C);
            send_key_bytes();
            if ($urandom_range(0, 2) == 0) begin
               send_item(REQ_BYTE, CH_C);
               send_key_bytes();
            end
            if ($urandom_range(0, 5) == 0) send_noise();
            send_item(REQ_BYTE, CH_A);
            repeat ($urandom_range(0, 2)) send_noise();
         end else begin
            send_noise();
            repeat ($urandom_range(0, 2)) send_noise();
            send_item(REQ_BYTE, CH_A);
            send_key_bytes();
            repeat ($urandom_range(0, 2)) send_noise();
         end
         drain_link();
         session++;
      end

      if (sb.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      int            stall;
      link_beat_type got;
      wait (reset === 1'b0);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            stall = gaps_on ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got.has_byte        = rsp_tuser[0];
         got.tx_byte         = rsp_tdata[7:0];
         got.last            = rsp_tlast;
         got.connected       = rsp_tuser[1];
         got.peer_public_key = rsp_tdata[39:8];
         got.peer_modulus    = rsp_tdata[71:40];
         sb.check_link_beat(got);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      wait (reset === 1'b0);
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("FAILURE");
      $finish;
   end

endmodule

[filelist.f]
rtl/kehs_pkg.sv
rtl/kehs_fsm.sv
rtl/kehs_emit.sv
rtl/key_exchange_handshake_fsm_core.sv
dv/kehs_check_pkg.sv
dv/testbench.sv
